// ===== sv/sgi_pkg.sv =====
// Shared types and outcome codes for the segment intersection core.
package sgi_pkg;

    typedef enum logic [1:0] {
        OUT_HIT  = 2'd0,
        OUT_PAR  = 2'd1,
        OUT_MISS = 2'd2
    } t_outcome;

    localparam int OUTCOME_W = 2;

endpackage

// ===== sv/sgi_front.sv =====
// Front pipeline: coordinate differences, cross products, denominator and numerators.
module sgi_front #(
    parameter int W = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [8*W-1:0]          i_data,
    output logic                    o_valid,
    output logic signed [2*W+2:0]   o_den,
    output logic signed [2*W+2:0]   o_na,
    output logic signed [2*W+2:0]   o_nb,
    output logic signed [W:0]       o_dxa,
    output logic signed [W:0]       o_dya,
    output logic [W-1:0]            o_x1,
    output logic [W-1:0]            o_y1
);
    localparam int DFW = W + 1;
    localparam int PRW = 2 * W + 2;
    localparam int NW  = 2 * W + 3;

    logic signed [DFW-1:0] c [8];
    logic signed [DFW-1:0] n_dxa, n_dya, n_dxb, n_dyb, n_ox, n_oy;

    // stage 1 registers
    logic [2:0]            r_vld;
    logic signed [DFW-1:0] r_dxa, r_dya, r_dxb, r_dyb, r_ox, r_oy;
    logic [W-1:0]          r1_x1, r1_y1;
    // stage 2 registers
    logic signed [PRW-1:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    logic signed [DFW-1:0] r2_dxa, r2_dya;
    logic [W-1:0]          r2_x1, r2_y1;
    // stage 3 registers
    logic signed [NW-1:0]  r_den, r_na, r_nb;
    logic signed [DFW-1:0] r3_dxa, r3_dya;
    logic [W-1:0]          r3_x1, r3_y1;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            c[i] = $signed({i_data[i*W+W-1], i_data[i*W +: W]});
        end
        n_dxa = c[2] - c[0];
        n_dya = c[3] - c[1];
        n_dxb = c[6] - c[4];
        n_dyb = c[7] - c[5];
        n_ox  = c[0] - c[4];
        n_oy  = c[1] - c[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dxa <= n_dxa;
            r_dya <= n_dya;
            r_dxb <= n_dxb;
            r_dyb <= n_dyb;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r1_x1 <= i_data[W-1:0];
            r1_y1 <= i_data[2*W-1:W];

            r_p1   <= PRW'(r_dyb * r_dxa);
            r_p2   <= PRW'(r_dxb * r_dya);
            r_p3   <= PRW'(r_dxb * r_oy);
            r_p4   <= PRW'(r_dyb * r_ox);
            r_p5   <= PRW'(r_dxa * r_oy);
            r_p6   <= PRW'(r_dya * r_ox);
            r2_dxa <= r_dxa;
            r2_dya <= r_dya;
            r2_x1  <= r1_x1;
            r2_y1  <= r1_y1;

            r_den  <= NW'(r_p1) - NW'(r_p2);
            r_na   <= NW'(r_p3) - NW'(r_p4);
            r_nb   <= NW'(r_p5) - NW'(r_p6);
            r3_dxa <= r2_dxa;
            r3_dya <= r2_dya;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
        end
    end

    assign o_valid = r_vld[2];
    assign o_den   = r_den;
    assign o_na    = r_na;
    assign o_nb    = r_nb;
    assign o_dxa   = r3_dxa;
    assign o_dya   = r3_dya;
    assign o_x1    = r3_x1;
    assign o_y1    = r3_y1;

endmodule

// ===== sv/sgi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband carried along.
module sgi_div #(
    parameter int NW = 51,
    parameter int DW = 34,
    parameter int QW = 17,
    parameter int SW = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    logic          r_vld  [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_dv   [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] rem_in, dsh, n_rem;
        logic [QW-1:0] q_in, n_quo;
        logic [DW-1:0] dv_in;
        logic [SW-1:0] side_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_num;
            assign q_in    = '0;
            assign dv_in   = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_quo[k-1];
            assign dv_in   = r_dv[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            dsh   = {{(NW-DW){1'b0}}, dv_in} << (QW - 1 - k);
            n_rem = rem_in;
            n_quo = q_in;
            if (rem_in >= dsh) begin
                n_rem = rem_in - dsh;
                n_quo[QW-1-k] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_dv[k]   <= dv_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== sv/segment_intersection_core.sv =====
// Top level: segment pair intersection test with pipelined point computation.
//
//  channel | direction | tdata                                      | tuser
//  s       | in        | ax0, ay0, ax1, ay1, bx0, by0, bx1, by1     | -
//  m       | out       | hit_x, hit_y                               | outcome
//
// One segment pair per cycle while the output is not stalled; stages: 3 front stages
// (differences, products, den/na/nb), classify, two partial-product stages,
// COORD_WIDTH + 1 divider stages (one quotient bit each), output add.
// Reset (synchronous, active low) clears all stage valid bits.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, nothing is dropped or repeated.
module segment_intersection_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (lowest first)
    input  logic [8*COORD_WIDTH-1:0]                  s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // hit_x, hit_y (lowest first), zero padded to bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    // outcome
    output logic [sgi_pkg::OUTCOME_W-1:0]             m_tuser
);
    import sgi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DFW = W + 1;
    localparam int NW  = 2 * W + 3;
    localparam int MW  = 2 * W + 2;
    localparam int HW  = MW - DFW;
    localparam int PW  = MW + DFW;
    localparam int OW  = ((2 * W + 7) / 8) * 8;
    localparam int XSW = OUTCOME_W + 1 + W;
    localparam int YSW = 1 + W;

    logic en;

    logic                  f_valid;
    logic signed [NW-1:0]  f_den, f_na, f_nb;
    logic signed [DFW-1:0] f_dxa, f_dya;
    logic [W-1:0]          f_x1, f_y1;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    sgi_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_tvalid),
        .i_data  (s_tdata),
        .o_valid (f_valid),
        .o_den   (f_den),
        .o_na    (f_na),
        .o_nb    (f_nb),
        .o_dxa   (f_dxa),
        .o_dya   (f_dya),
        .o_x1    (f_x1),
        .o_y1    (f_y1)
    );

    // classify
    logic                  unit_a, unit_b;
    t_outcome              n_oc;
    logic [NW-1:0]         an_full, ad_full;

    function automatic logic in_unit(logic signed [NW-1:0] num, logic signed [NW-1:0] den);
        logic le_zero, ge_zero;
        le_zero = num[NW-1] || (num == '0);
        ge_zero = !num[NW-1];
        if (den[NW-1]) begin
            in_unit = (den <= num) && le_zero;
        end else begin
            in_unit = ge_zero && (num <= den);
        end
    endfunction

    always_comb begin
        unit_a  = in_unit(f_na, f_den);
        unit_b  = in_unit(f_nb, f_den);
        an_full = f_na[NW-1]  ? NW'(-f_na)  : NW'(f_na);
        ad_full = f_den[NW-1] ? NW'(-f_den) : NW'(f_den);
        if (f_den == '0) begin
            n_oc = OUT_PAR;
        end else if (unit_a && unit_b) begin
            n_oc = OUT_HIT;
        end else begin
            n_oc = OUT_MISS;
        end
    end

    logic [2:0]     r_vld;
    t_outcome       r4_oc, r5_oc, r6_oc;
    logic [MW-1:0]  r4_an, r4_ad, r5_ad, r6_ad;
    logic [DFW-1:0] r4_mx, r4_my;
    logic           r4_sx, r4_sy, r5_sx, r5_sy, r6_sx, r6_sy;
    logic [W-1:0]   r4_x1, r4_y1, r5_x1, r5_y1, r6_x1, r6_y1;
    logic [2*DFW-1:0] r5_pxl, r5_pyl;
    logic [2*HW-1:0]  r5_pxh, r5_pyh;
    logic [PW-1:0]  r6_px, r6_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[1:0], f_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_oc <= n_oc;
            r4_an <= an_full[MW-1:0];
            r4_ad <= ad_full[MW-1:0];
            r4_mx <= f_dxa[DFW-1] ? DFW'(-f_dxa) : DFW'(f_dxa);
            r4_my <= f_dya[DFW-1] ? DFW'(-f_dya) : DFW'(f_dya);
            r4_sx <= f_na[NW-1] ^ f_dxa[DFW-1] ^ f_den[NW-1];
            r4_sy <= f_na[NW-1] ^ f_dya[DFW-1] ^ f_den[NW-1];
            r4_x1 <= f_x1;
            r4_y1 <= f_y1;

            // |na| split into two halves for the point products
            r5_pxl <= r4_an[DFW-1:0] * r4_mx;
            r5_pyl <= r4_an[DFW-1:0] * r4_my;
            r5_pxh <= r4_an[MW-1:DFW] * HW'(r4_mx);
            r5_pyh <= r4_an[MW-1:DFW] * HW'(r4_my);
            r5_oc  <= r4_oc;
            r5_ad  <= r4_ad;
            r5_sx  <= r4_sx;
            r5_sy  <= r4_sy;
            r5_x1  <= r4_x1;
            r5_y1  <= r4_y1;

            r6_px <= PW'(r5_pxl) + (PW'(r5_pxh) << DFW);
            r6_py <= PW'(r5_pyl) + (PW'(r5_pyh) << DFW);
            r6_oc <= r5_oc;
            r6_ad <= r5_ad;
            r6_sx <= r5_sx;
            r6_sy <= r5_sy;
            r6_x1 <= r5_x1;
            r6_y1 <= r5_y1;
        end
    end

    logic           dx_valid;
    logic [DFW-1:0] qx, qy;
    logic [XSW-1:0] sdx;
    logic [YSW-1:0] sdy;

    sgi_div #(.NW(PW), .DW(MW), .QW(DFW), .SW(XSW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[2]),
        .i_num   (r6_px),
        .i_den   (r6_ad),
        .i_side  ({r6_oc, r6_sx, r6_x1}),
        .o_valid (dx_valid),
        .o_quo   (qx),
        .o_side  (sdx)
    );

    sgi_div #(.NW(PW), .DW(MW), .QW(DFW), .SW(YSW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vld[2]),
        .i_num   (r6_py),
        .i_den   (r6_ad),
        .i_side  ({r6_sy, r6_y1}),
        .o_valid (),
        .o_quo   (qy),
        .o_side  (sdy)
    );

    // output stage
    t_outcome     d_oc;
    logic [W:0]   n_rx, n_ry;
    logic         r_out_valid;
    t_outcome     r_oc;
    logic [W-1:0] r_hx, r_hy;

    always_comb begin
        d_oc = t_outcome'(sdx[XSW-1 -: OUTCOME_W]);
        n_rx = sdx[W] ? ({1'b0, sdx[W-1:0]} - (W+1)'(qx)) : ({1'b0, sdx[W-1:0]} + (W+1)'(qx));
        n_ry = sdy[W] ? ({1'b0, sdy[W-1:0]} - (W+1)'(qy)) : ({1'b0, sdy[W-1:0]} + (W+1)'(qy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oc <= d_oc;
            r_hx <= (d_oc == OUT_HIT) ? n_rx[W-1:0] : '0;
            r_hy <= (d_oc == OUT_HIT) ? n_ry[W-1:0] : '0;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_oc;
    assign m_tdata  = OW'({r_hy, r_hx});

endmodule

// ===== sv/sgi_checker.sv =====
// Port-level checker for the segment intersection core, bound to the top level.
module sgi_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_tready,
    input logic                                   i_m_tvalid,
    input logic                                   i_m_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]     i_m_tdata,
    input logic [sgi_pkg::OUTCOME_W-1:0]          i_m_tuser
);
    import sgi_pkg::*;

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == OUT_HIT || i_m_tuser == OUT_PAR || i_m_tuser == OUT_MISS))
        else $error("outcome code out of range");

    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser != OUT_HIT) |-> (i_m_tdata == '0))
        else $error("point not zero without a hit");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input stalled while output empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed");

endmodule

bind segment_intersection_core sgi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sgi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser)
);
